// ===== rtl/scene_hierarchy_bytecode_decoder_top_assert.svh =====
// Assertion macros for the scene hierarchy bytecode decoder.
`ifndef SCENE_HIERARCHY_BYTECODE_DECODER_TOP_ASSERT_SVH
`define SCENE_HIERARCHY_BYTECODE_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SHBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SHBD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHBD_ASSERT(lbl, clk, rstn, prop, msg)
`define SHBD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/shbd_pkg.sv =====
// Package: codes, payload types and control structs of the bytecode decoder.
`default_nettype none
package shbd_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int WORD_W = 16;
    localparam int KIND_W = 2;

    localparam logic [WORD_W-1:0] OP_END      = 16'h0000;
    localparam logic [WORD_W-1:0] OP_OPEN     = 16'h0001;
    localparam logic [WORD_W-1:0] OP_CLOSE    = 16'h0002;
    localparam logic [WORD_W-1:0] OP_JOINT    = 16'h0010;
    localparam logic [WORD_W-1:0] OP_MATERIAL = 16'h0011;
    localparam logic [WORD_W-1:0] OP_SHAPE    = 16'h0012;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_JOINT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MATERIAL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SHAPE    = 2'd3;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_LINK    = 3'd1;
    localparam logic [2:0] EV_DISPLAY = 3'd2;
    localparam logic [2:0] EV_ERROR   = 3'd3;
    localparam logic [2:0] EV_END     = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OPCODE    = 3'd1;
    localparam logic [2:0] ERR_MATERIAL  = 3'd2;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] opcode;
        logic [WORD_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [WORD_W-1:0] parent_joint;
        logic [WORD_W-1:0] child_joint;
        logic [WORD_W-1:0] material;
        logic [WORD_W-1:0] shape;
        logic [2:0]        error_code;
    } res_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_ctl_t;

    typedef struct packed {
        logic              clear;
        logic              joint_we;
        logic              material_we;
        logic              kind_we;
        logic [KIND_W-1:0] kind;
    } state_upd_t;

endpackage
`default_nettype wire

// ===== rtl/shbd_stack.sv =====
// LIFO stack in a memory with a registered top-of-stack word.
`default_nettype none
`include "scene_hierarchy_bytecode_decoder_top_assert.svh"
module shbd_stack
    import shbd_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    parameter int DATA_W = WORD_W,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int LW = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire stack_ctl_t        ctl,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [LW-1:0]     level,
    output logic      [DATA_W-1:0] top
);

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [LW-1:0]     level_reg;
    logic [LW-1:0]     level_next;
    logic [LW-1:0]     below_next;
    logic [DATA_W-1:0] top_reg;
    logic              wr_en;

    always_comb begin
        if (ctl.clear) begin
            level_next = '0;
        end else if (ctl.push) begin
            level_next = level_reg + LW'(1);
        end else if (ctl.pop) begin
            level_next = level_reg - LW'(1);
        end else begin
            level_next = level_reg;
        end
    end

    assign below_next = level_next - LW'(1);
    assign wr_en      = ctl.push && !ctl.clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
        end
    end

    // top word follows the new level; a push bypasses the memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[level_reg[AW-1:0]] <= wdata;
        end
        if (wr_en) begin
            top_reg <= wdata;
        end else begin
            top_reg <= mem[below_next[AW-1:0]];
        end
    end

    assign level = level_reg;
    assign top   = top_reg;

    `SHBD_ASSERT(a_level_bound, aclk, aresetn, level_reg <= LW'(STACK_DEPTH), "level past depth")
    `SHBD_ASSERT(a_no_push_full, aclk, aresetn, wr_en |-> level_reg != LW'(STACK_DEPTH), "push on full")
    `SHBD_ASSERT(a_no_pop_empty, aclk, aresetn, (ctl.pop && !ctl.clear) |-> level_reg != '0, "pop on empty")
    `SHBD_ASSERT(a_push_grows, aclk, aresetn, wr_en |=> level_reg == $past(level_reg) + LW'(1), "push lost")

endmodule
`default_nettype wire

// ===== rtl/shbd_decode.sv =====
// Command decode: result and state updates for one bytecode command.
`default_nettype none
module shbd_decode
    import shbd_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    localparam int LW = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic              fire,
    input  wire cmd_t              cmd,
    input  wire logic [WORD_W-1:0] material_count,
    input  wire logic [WORD_W-1:0] current_joint,
    input  wire logic [WORD_W-1:0] current_material,
    input  wire logic [KIND_W-1:0] last_kind,
    input  wire logic [KIND_W-1:0] kind_top,
    input  wire logic [LW-1:0]     kind_level,
    input  wire logic [WORD_W-1:0] joint_top,
    input  wire logic [LW-1:0]     joint_level,
    output res_t                   res,
    output stack_ctl_t             kind_ctl,
    output stack_ctl_t             joint_ctl,
    output state_upd_t             upd
);

    stack_ctl_t kind_c;
    stack_ctl_t joint_c;
    state_upd_t upd_c;
    logic       after_joint;

    assign after_joint = (last_kind == KIND_JOINT);

    always_comb begin
        res     = '0;
        kind_c  = '0;
        joint_c = '0;
        upd_c   = '0;
        case (cmd.opcode)
            OP_END: begin
                res.event_res = EV_END;
                kind_c.clear  = 1'b1;
                joint_c.clear = 1'b1;
                upd_c.clear   = 1'b1;
            end
            OP_OPEN: begin
                if (kind_level == LW'(STACK_DEPTH) ||
                    (after_joint && joint_level == LW'(STACK_DEPTH))) begin
                    res.event_res  = EV_ERROR;
                    res.error_code = ERR_OVERFLOW;
                end else begin
                    kind_c.push  = 1'b1;
                    joint_c.push = after_joint;
                end
            end
            OP_CLOSE: begin
                if (kind_level == '0) begin
                    res.event_res  = EV_ERROR;
                    res.error_code = ERR_UNDERFLOW;
                end else begin
                    kind_c.pop  = 1'b1;
                    joint_c.pop = (kind_top == KIND_JOINT) && (joint_level != '0);
                end
            end
            OP_JOINT: begin
                if (joint_level != '0) begin
                    res.event_res    = EV_LINK;
                    res.parent_joint = joint_top;
                    res.child_joint  = cmd.index;
                end
                upd_c.joint_we = 1'b1;
                upd_c.kind_we  = 1'b1;
                upd_c.kind     = KIND_JOINT;
            end
            OP_MATERIAL: begin
                upd_c.material_we = 1'b1;
                upd_c.kind_we     = 1'b1;
                upd_c.kind        = KIND_MATERIAL;
            end
            OP_SHAPE: begin
                if (current_material >= material_count) begin
                    res.event_res  = EV_ERROR;
                    res.error_code = ERR_MATERIAL;
                end else begin
                    res.event_res   = EV_DISPLAY;
                    res.child_joint = current_joint;
                    res.material    = current_material;
                    res.shape       = cmd.index;
                    upd_c.kind_we   = 1'b1;
                    upd_c.kind      = KIND_SHAPE;
                end
            end
            default: begin
                res.event_res  = EV_ERROR;
                res.error_code = ERR_OPCODE;
            end
        endcase
    end

    assign kind_ctl  = fire ? kind_c : '0;
    assign joint_ctl = fire ? joint_c : '0;
    assign upd       = fire ? upd_c : '0;

endmodule
`default_nettype wire

// ===== rtl/scene_hierarchy_bytecode_decoder_top.sv =====
// Scene hierarchy bytecode decoder: command register, decode, result register.
// Throughput: one command per cycle, but a command waits in the command register
// while a held result is not taken; the kind and joint stacks are memories with
// a registered top word that is refilled by the same edge that moves the level.
// Reset (aresetn low, synchronous): pipeline empty, stacks empty, current joint,
// material and last kind cleared, material_count zero.
`default_nettype none
`include "scene_hierarchy_bytecode_decoder_top_assert.svh"
module scene_hierarchy_bytecode_decoder_top
    import shbd_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cmd_t              s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output res_t                   m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [WORD_W-1:0] cfg_data
);

    localparam int LW = $clog2(STACK_DEPTH + 1);

    cmd_t              cmd_reg;
    logic              cmd_valid_reg;
    logic              cmd_valid_next;
    res_t              res_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [WORD_W-1:0] mcount_reg;
    logic [WORD_W-1:0] joint_reg;
    logic [WORD_W-1:0] joint_next;
    logic [WORD_W-1:0] material_reg;
    logic [WORD_W-1:0] material_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;

    logic              advance;
    logic              s_fire;
    res_t              res;
    stack_ctl_t        kind_ctl;
    stack_ctl_t        joint_ctl;
    state_upd_t        upd;
    logic [KIND_W-1:0] kind_top;
    logic [LW-1:0]     kind_level;
    logic [WORD_W-1:0] joint_top;
    logic [LW-1:0]     joint_level;

    assign advance   = cmd_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready   = !cmd_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    shbd_decode #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_decode (
        .fire             (advance),
        .cmd              (cmd_reg),
        .material_count   (mcount_reg),
        .current_joint    (joint_reg),
        .current_material (material_reg),
        .last_kind        (kind_reg),
        .kind_top         (kind_top),
        .kind_level       (kind_level),
        .joint_top        (joint_top),
        .joint_level      (joint_level),
        .res              (res),
        .kind_ctl         (kind_ctl),
        .joint_ctl        (joint_ctl),
        .upd              (upd)
    );

    shbd_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_W     (KIND_W)
    ) u_kind_stack (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (kind_ctl),
        .wdata  (kind_reg),
        .level  (kind_level),
        .top    (kind_top)
    );

    shbd_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_W     (WORD_W)
    ) u_joint_stack (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (joint_ctl),
        .wdata  (joint_reg),
        .level  (joint_level),
        .top    (joint_top)
    );

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (s_fire) begin
            cmd_valid_next = 1'b1;
        end else if (advance) begin
            cmd_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (advance) begin
            res_valid_next = 1'b1;
        end else if (m_ready) begin
            res_valid_next = 1'b0;
        end
        joint_next    = joint_reg;
        material_next = material_reg;
        kind_next     = kind_reg;
        if (upd.clear) begin
            joint_next    = '0;
            material_next = '0;
            kind_next     = KIND_NONE;
        end else begin
            if (upd.joint_we) begin
                joint_next = cmd_reg.index;
            end
            if (upd.material_we) begin
                material_next = cmd_reg.index;
            end
            if (upd.kind_we) begin
                kind_next = upd.kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            mcount_reg    <= '0;
            joint_reg     <= '0;
            material_reg  <= '0;
            kind_reg      <= KIND_NONE;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
            joint_reg     <= joint_next;
            material_reg  <= material_next;
            kind_reg      <= kind_next;
            if (cfg_valid && cfg_ready) begin
                mcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= s_data;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

    `SHBD_ASSERT(a_err_has_code, aclk, aresetn,
        (res_valid_reg && res_reg.event_res == EV_ERROR) |-> res_reg.error_code != ERR_NONE,
        "error without code")
    `SHBD_ASSERT(a_ok_no_code, aclk, aresetn,
        (res_valid_reg && res_reg.event_res != EV_ERROR) |-> res_reg.error_code == ERR_NONE,
        "code on non-error")
    `SHBD_ASSERT(a_ready_when_empty, aclk, aresetn, !cmd_valid_reg |-> s_ready,
        "stall with empty command register")
    `SHBD_ASSERT(a_end_clears, aclk, aresetn,
        (advance && cmd_reg.opcode == OP_END) |=> (kind_level == '0 && joint_level == '0),
        "terminate left stack")

endmodule
`default_nettype wire

// ===== dv/scene_decoder_checker.sv =====
// Checker for the scene hierarchy bytecode decoder: predicts and compares each result.
`timescale 1ns / 1ps
module scene_decoder_checker
    import shbd_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  cmd_t              s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  res_t              m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data,
    output int                pending_results,
    output int                mismatch_count
);

    logic [KIND_W-1:0] open_kinds [STACK_DEPTH];
    logic [WORD_W-1:0] joint_path [STACK_DEPTH];
    int                kind_level;
    int                joint_level;
    logic [WORD_W-1:0] cur_joint;
    logic [WORD_W-1:0] cur_material;
    logic [KIND_W-1:0] prev_kind;
    logic [WORD_W-1:0] material_limit;
    res_t              expected_results [$];
    int                mismatches = 0;

    assign mismatch_count = mismatches;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_scene();
        kind_level   = 0;
        joint_level  = 0;
        cur_joint    = '0;
        cur_material = '0;
        prev_kind    = KIND_NONE;
    endfunction

    function automatic res_t decode_command(input cmd_t c);
        res_t r;
        r = '0;
        r.event_res  = EV_NONE;
        r.error_code = ERR_NONE;
        case (c.opcode)
            OP_END: begin
                clear_scene();
                r.event_res = EV_END;
            end
            OP_OPEN: begin
                if (kind_level >= STACK_DEPTH ||
                    (prev_kind == KIND_JOINT && joint_level >= STACK_DEPTH)) begin
                    r.event_res  = EV_ERROR;
                    r.error_code = ERR_OVERFLOW;
                end else begin
                    if (prev_kind == KIND_JOINT) begin
                        joint_path[joint_level] = cur_joint;
                        joint_level++;
                    end
                    open_kinds[kind_level] = prev_kind;
                    kind_level++;
                end
            end
            OP_CLOSE: begin
                if (kind_level == 0) begin
                    r.event_res  = EV_ERROR;
                    r.error_code = ERR_UNDERFLOW;
                end else begin
                    kind_level--;
                    if (open_kinds[kind_level] == KIND_JOINT && joint_level > 0)
                        joint_level--;
                end
            end
            OP_JOINT: begin
                if (joint_level > 0) begin
                    r.event_res    = EV_LINK;
                    r.parent_joint = joint_path[joint_level - 1];
                    r.child_joint  = c.index;
                end
                cur_joint = c.index;
                prev_kind = KIND_JOINT;
            end
            OP_MATERIAL: begin
                cur_material = c.index;
                prev_kind    = KIND_MATERIAL;
            end
            OP_SHAPE: begin
                if (cur_material >= material_limit) begin
                    r.event_res  = EV_ERROR;
                    r.error_code = ERR_MATERIAL;
                end else begin
                    r.event_res   = EV_DISPLAY;
                    r.child_joint = cur_joint;
                    r.material    = cur_material;
                    r.shape       = c.index;
                    prev_kind     = KIND_SHAPE;
                end
            end
            default: begin
                r.event_res  = EV_ERROR;
                r.error_code = ERR_OPCODE;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            clear_scene();
            material_limit = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                material_limit = cfg_data;
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), decode_command(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no command pending, event_res",
                                    WORD_W'(m_data.event_res), WORD_W'(EV_NONE));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.event_res !== want.event_res)
                        report_mismatch("event_res", WORD_W'(m_data.event_res),
                                        WORD_W'(want.event_res));
                    if (m_data.parent_joint !== want.parent_joint)
                        report_mismatch("parent_joint", m_data.parent_joint, want.parent_joint);
                    if (m_data.child_joint !== want.child_joint)
                        report_mismatch("child_joint", m_data.child_joint, want.child_joint);
                    if (m_data.material !== want.material)
                        report_mismatch("material", m_data.material, want.material);
                    if (m_data.shape !== want.shape)
                        report_mismatch("shape", m_data.shape, want.shape);
                    if (m_data.error_code !== want.error_code)
                        report_mismatch("error_code", WORD_W'(m_data.error_code),
                                        WORD_W'(want.error_code));
                end
            end
        end
        pending_results <= expected_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Testbench top for the scene hierarchy bytecode decoder: stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import shbd_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 125;
    localparam int DEEP_OPENS    = DEFAULT_STACK_DEPTH + 2;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    cmd_t              s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    res_t              m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_data  = '0;

    int pending_results;
    int mismatch_count;
    int cycle_count   = 0;
    bit idle_enabled  = 1'b1;
    bit hold_output   = 1'b0;

    scene_hierarchy_bytecode_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    scene_decoder_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_command(input logic [WORD_W-1:0] op, input logic [WORD_W-1:0] idx);
        cmd_t c;
        c.opcode = op;
        c.index  = idx;
        if (idle_enabled && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_material_count(input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_command(input logic [WORD_W-1:0] limit);
        int                pick;
        logic [WORD_W-1:0] op;
        logic [WORD_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idx  = WORD_W'($urandom_range(0, 65535));
        if (pick < 3)
            op = OP_END;
        else if (pick < 23)
            op = OP_OPEN;
        else if (pick < 41)
            op = OP_CLOSE;
        else if (pick < 61)
            op = OP_JOINT;
        else if (pick < 75) begin
            op = OP_MATERIAL;
            if ($urandom_range(0, 1))
                idx = WORD_W'($urandom_range(0, int'(limit)));
        end else if (pick < 93)
            op = OP_SHAPE;
        else
            op = WORD_W'($urandom_range(0, 65535));
        send_command(op, idx);
    endtask

    // nest past the stack depth under a joint, then unwind past empty
    task automatic send_deep_nest();
        send_command(OP_JOINT, WORD_W'($urandom_range(0, 65535)));
        repeat (DEEP_OPENS) begin
            send_command(OP_OPEN, WORD_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 3) == 0)
                send_command(OP_JOINT, WORD_W'($urandom_range(0, 65535)));
        end
        repeat (DEEP_OPENS + 1)
            send_command(OP_CLOSE, WORD_W'($urandom_range(0, 65535)));
    endtask

    initial begin
        logic [WORD_W-1:0] limits [5];
        int                deep_at;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // material count still at its reset value of zero
        send_command(OP_CLOSE, 16'h0000);
        send_command(16'hFFFF, 16'hFFFF);
        send_command(16'h0003, 16'h0000);
        send_command(OP_SHAPE, 16'h0000);
        send_command(OP_JOINT, 16'hFFFF);
        send_command(OP_OPEN, 16'h0000);
        send_command(OP_JOINT, 16'h0000);
        send_command(OP_MATERIAL, 16'hFFFF);
        send_command(OP_SHAPE, 16'h1234);
        send_command(OP_CLOSE, 16'h0000);
        send_command(OP_CLOSE, 16'h0000);
        send_command(OP_END, 16'hFFFF);
        wait_until_drained();

        write_material_count(16'hFFFF);
        send_command(OP_MATERIAL, 16'hFFFE);
        send_command(OP_JOINT, 16'h8001);
        send_command(OP_SHAPE, 16'hFFFF);
        send_command(OP_OPEN, 16'h0000);
        send_command(OP_JOINT, 16'h0001);
        send_command(OP_OPEN, 16'h0000);
        send_command(OP_MATERIAL, 16'hFFFF);
        send_command(OP_SHAPE, 16'h0000);
        send_command(OP_JOINT, 16'hFFFF);
        send_command(OP_END, 16'h0000);
        send_command(OP_JOINT, 16'h0005);
        send_command(OP_SHAPE, 16'h0000);
        wait_until_drained();

        limits[0] = 16'd16;
        limits[1] = 16'd1;
        limits[2] = WORD_W'($urandom_range(2, 65534));
        limits[3] = 16'hFFFF;
        limits[4] = 16'd0;
        for (int p = 0; p < 5; p++) begin
            write_material_count(limits[p]);
            if (p == 0)
                hold_output = 1'b1;
            if (p == 4)
                idle_enabled = 1'b0;
            deep_at = (p % 2 == 0) ? int'($urandom_range(0, PHASE_ITEMS - 1)) : -1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == deep_at)
                    send_deep_nest();
                send_random_command(limits[p]);
            end
            wait_until_drained();
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
